// ===== rtl/core/tpma_pkg.sv =====
// Package for the two-level page map allocator.
// Holds widths, table geometry, payload and inter-module types. No dependencies.
package tpma_pkg;

  localparam int unsigned TASK_COUNT  = 4;
  localparam int unsigned OFFSET_BITS = 10;
  localparam int unsigned OUTER_BITS  = 6;
  localparam int unsigned INNER_BITS  = 6;

  localparam int unsigned TASK_W    = 2;
  localparam int unsigned VA_W      = 22;
  localparam int unsigned AMOUNT_W  = 10;
  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned PADDR_W   = 33;
  localparam int unsigned BYTES_W   = 34;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned KB_SHIFT  = 10;
  localparam int unsigned MB_SHIFT  = 20;

  localparam int unsigned TASK_SEL_W  = $clog2(TASK_COUNT);
  localparam int unsigned INDEX_BITS  = OUTER_BITS + INNER_BITS;
  localparam int unsigned MAP_IDX_W   = TASK_SEL_W + INDEX_BITS;
  localparam int unsigned MAP_DEPTH   = TASK_COUNT << INDEX_BITS;
  localparam int unsigned ENTRY_W     = PADDR_W + 1;
  localparam int unsigned REQ_BYTES_W = AMOUNT_W + MB_SHIFT;
  localparam int unsigned NEED_W      = REQ_BYTES_W - OFFSET_BITS;

  localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(8388608);
  localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  typedef struct packed {
    logic [TASK_W-1:0]   task_id;
    logic [VA_W-1:0]     virtual_address;
    logic [AMOUNT_W-1:0] size_amount;
    logic                size_unit;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               out_of_memory;
    logic [PADDR_W-1:0] phys_addr;
    logic [BYTES_W-1:0] task_bytes;
    logic [BYTES_W-1:0] total_bytes;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                   task_ok;
    logic [TASK_SEL_W-1:0]  task_sel;
    logic [MAP_IDX_W-1:0]   idx;
    logic [OFFSET_BITS-1:0] off;
    logic [REQ_BYTES_W-1:0] bytes;
    logic [NEED_W-1:0]      need;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } fr_item_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } bk_ctrl_t;

endpackage

// ===== rtl/core/tpma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tpma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tpma_front.sv =====
// Front end: accepts requests, splits the address, sizes the request,
// and queues classified items for the back end. Uses tpma_pkg.
module tpma_front import tpma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  req_t     req_i,
  input  bk_ctrl_t ctrl_i,
  output fr_item_t item_o
);

  localparam int unsigned QDEPTH = 2;

  work_t      q_mem_q [QDEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  work_t      cls;
  logic [REQ_BYTES_W-1:0] amount_ext;

  always_comb begin
    amount_ext   = REQ_BYTES_W'(req_i.size_amount);
    cls.task_ok  = (int'(req_i.task_id) < TASK_COUNT);
    cls.task_sel = req_i.task_id[TASK_SEL_W-1:0];
    cls.idx      = {req_i.task_id[TASK_SEL_W-1:0],
                    req_i.virtual_address[OFFSET_BITS+INNER_BITS +: OUTER_BITS],
                    req_i.virtual_address[OFFSET_BITS +: INNER_BITS]};
    cls.off      = req_i.virtual_address[OFFSET_BITS-1:0];
    cls.bytes    = req_i.size_unit ? (amount_ext << MB_SHIFT) : (amount_ext << KB_SHIFT);
    cls.need     = cls.bytes[REQ_BYTES_W-1:OFFSET_BITS];
  end

  assign full_o       = (cnt_q == 2'(QDEPTH)) || ctrl_i.clearing;
  assign do_push      = push_i && !full_o;
  assign do_pop       = ctrl_i.take && (cnt_q != 2'd0);
  assign item_o.valid = (cnt_q != 2'd0);
  assign item_o.work  = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/tpma_back.sv =====
// Back end: table lookup, bump frame allocation, totals, result queue,
// and the table clearing sweep after reset. Uses tpma_pkg and tpma_ram.
module tpma_back import tpma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FRAME_W-1:0] cfg_wdata_i,
  input  fr_item_t           item_i,
  output bk_ctrl_t           ctrl_o,
  output rsp_t               rsp_o,
  output logic               empty_o,
  input  logic               pop_i
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RESOLVE} state_e;

  localparam int unsigned ODEPTH = 2;

  state_e             state_q;
  logic [MAP_IDX_W-1:0] clr_idx_q;
  logic [FRAME_W-1:0] frame_count_q, next_free_q;
  logic [BYTES_W-1:0] task_tot_q [TASK_COUNT];
  logic [BYTES_W-1:0] all_tot_q;
  logic [CNT_W-1:0]   hits_q, misses_q;
  work_t              work_q;

  rsp_t       out_mem_q [ODEPTH];
  logic       owr_ptr_q, ord_ptr_q;
  logic [1:0] ocnt_q;
  logic       opush, opop;

  logic                 ram_we, ram_re;
  logic [MAP_IDX_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

  logic               take, is_hit, no_frames, oom, alloc;
  logic [FRAME_W-1:0] remain, need_ext, next_free_d;
  logic [PADDR_W-1:0] paddr_new;
  logic [BYTES_W:0]   task_sum, all_sum;
  logic [BYTES_W-1:0] task_tot_d, all_tot_d;
  logic [CNT_W-1:0]   hits_d, misses_d;
  rsp_t               rsp_d;

  tpma_ram #(
    .Width(ENTRY_W),
    .Depth(MAP_DEPTH)
  ) u_map (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(item_i.work.idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    take      = (state_q == ST_IDLE) && item_i.valid && (ocnt_q < 2'(ODEPTH));
    ram_re    = take;

    is_hit    = work_q.task_ok && ram_rdata[ENTRY_W-1];
    no_frames = (next_free_q >= frame_count_q);
    remain    = frame_count_q - next_free_q;
    need_ext  = FRAME_W'(work_q.need);
    oom       = work_q.task_ok && !is_hit && (no_frames || (need_ext > remain));
    alloc     = work_q.task_ok && !is_hit && !oom;
    paddr_new = {next_free_q[PADDR_W-OFFSET_BITS-1:0], work_q.off};

    next_free_d = alloc ? (next_free_q + need_ext) : next_free_q;
    task_sum    = {1'b0, task_tot_q[work_q.task_sel]} + (BYTES_W+1)'(work_q.bytes);
    all_sum     = {1'b0, all_tot_q} + (BYTES_W+1)'(work_q.bytes);
    task_tot_d  = !alloc ? task_tot_q[work_q.task_sel] :
                  (task_sum[BYTES_W] ? BYTES_MAX : task_sum[BYTES_W-1:0]);
    all_tot_d   = !alloc ? all_tot_q :
                  (all_sum[BYTES_W] ? BYTES_MAX : all_sum[BYTES_W-1:0]);
    hits_d      = (is_hit && hits_q != CNT_MAX) ? hits_q + 1'b1 : hits_q;
    misses_d    = (alloc && misses_q != CNT_MAX) ? misses_q + 1'b1 : misses_q;

    rsp_d.hit              = is_hit;
    rsp_d.out_of_memory    = oom;
    rsp_d.phys_addr        = is_hit ? ram_rdata[PADDR_W-1:0] :
                             (alloc ? paddr_new : '0);
    rsp_d.task_bytes       = work_q.task_ok ? task_tot_d : '0;
    rsp_d.total_bytes      = all_tot_d;
    rsp_d.hit_count        = hits_d;
    rsp_d.miss_count       = misses_d;

    ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_RESOLVE) && alloc);
    ram_waddr = (state_q == ST_CLEAR) ? clr_idx_q : work_q.idx;
    ram_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, paddr_new};

    opush = (state_q == ST_RESOLVE);
    opop  = pop_i && (ocnt_q != 2'd0);

    ctrl_o.take     = take;
    ctrl_o.clearing = (state_q == ST_CLEAR);
  end

  assign empty_o = (ocnt_q == 2'd0);
  assign rsp_o   = out_mem_q[ord_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_idx_q     <= '0;
      frame_count_q <= FRAME_LIMIT;
      next_free_q   <= '0;
      all_tot_q     <= '0;
      hits_q        <= '0;
      misses_q      <= '0;
      owr_ptr_q     <= 1'b0;
      ord_ptr_q     <= 1'b0;
      ocnt_q        <= 2'd0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        task_tot_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= (cfg_wdata_i > FRAME_LIMIT) ? FRAME_LIMIT : cfg_wdata_i;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == MAP_IDX_W'(MAP_DEPTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) state_q <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          next_free_q <= next_free_d;
          all_tot_q   <= all_tot_d;
          hits_q      <= hits_d;
          misses_q    <= misses_d;
          if (alloc) task_tot_q[work_q.task_sel] <= task_tot_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (opush) owr_ptr_q <= ~owr_ptr_q;
      if (opop)  ord_ptr_q <= ~ord_ptr_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) work_q <= item_i.work;
    if (opush) out_mem_q[owr_ptr_q] <= rsp_d;
  end

endmodule

// ===== rtl/core/two_level_page_map_allocator.sv =====
// Two-level page map allocator, top level. Uses tpma_pkg, tpma_front, tpma_back.
// Path: a push is queued in the front end, then the back end reads the map table and resolves it.
// The back end takes a new request only after the last one is resolved (map RAM read, then write-back).
// Reset: counters and totals cleared, frame_count to its limit; a sweep then
// invalidates all 16384 map entries, with full held high meanwhile.
module two_level_page_map_allocator import tpma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  req_t               req_i,
  output logic               empty,
  input  logic               pop,
  output rsp_t               rsp_o,
  input  logic               cfg_we_i,
  input  logic [FRAME_W-1:0] cfg_wdata_i
);

  fr_item_t item;
  bk_ctrl_t ctrl;

  tpma_front u_front (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .full_o(full),
    .req_i,
    .ctrl_i(ctrl),
    .item_o(item)
  );

  tpma_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .item_i (item),
    .ctrl_o (ctrl),
    .rsp_o,
    .empty_o(empty),
    .pop_i  (pop)
  );

endmodule

// ===== bench/tb_two_level_page_map_allocator.sv =====
// Self-checking bench for two_level_page_map_allocator: directed and random
// requests with a built-in page map predictor. Depends on tpma_pkg and the RTL.
module tb_two_level_page_map_allocator;
  import tpma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 3;
  localparam int QUIET_LIMIT = 100000;
  localparam int PHASE_ITEMS = 250;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               full;
  req_t               req_d     = '0;
  logic               empty;
  logic               pop       = 1'b0;
  rsp_t               rsp;
  logic               cfg_we    = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata = '0;

  two_level_page_map_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_d),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state
  logic [ENTRY_W-1:0] page_map [MAP_DEPTH];
  logic [FRAME_W-1:0] free_frame;
  logic [FRAME_W-1:0] frame_limit;
  logic [BYTES_W-1:0] task_bytes [TASK_COUNT];
  logic [BYTES_W-1:0] all_bytes;
  logic [CNT_W-1:0]   hits_seen;
  logic [CNT_W-1:0]   misses_seen;

  req_t request_q [$];
  rsp_t mapping_q [$];
  bit   idle_on = 1'b1;
  int   error_count = 0;
  int   push_gap = 0;
  int   pop_gap = 0;
  int   quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [BYTES_W-1:0] saturating_sum(logic [BYTES_W-1:0] a,
                                                        logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'(BYTES_MAX)) ? BYTES_MAX : s[BYTES_W-1:0];
  endfunction

  function automatic rsp_t predict_translation(req_t r);
    rsp_t                 o;
    logic [MAP_IDX_W-1:0] idx;
    logic [63:0]          bytes;
    logic [63:0]          need;
    logic [63:0]          remain;
    logic [63:0]          paddr;
    o = '0;
    idx = {r.task_id, r.virtual_address[OFFSET_BITS +: INDEX_BITS]};
    if (page_map[idx][PADDR_W]) begin
      o.hit = 1'b1;
      o.phys_addr = page_map[idx][PADDR_W-1:0];
      if (hits_seen != CNT_MAX) hits_seen++;
    end else begin
      bytes = 64'(r.size_amount) << (r.size_unit ? MB_SHIFT : KB_SHIFT);
      need = bytes >> OFFSET_BITS;
      remain = (free_frame < frame_limit) ? 64'(frame_limit - free_frame) : 64'd0;
      if (remain == 0 || need > remain) begin
        o.out_of_memory = 1'b1;
      end else begin
        paddr = (64'(free_frame) << OFFSET_BITS) + 64'(r.virtual_address[OFFSET_BITS-1:0]);
        o.phys_addr = paddr[PADDR_W-1:0];
        page_map[idx] = {1'b1, paddr[PADDR_W-1:0]};
        free_frame = free_frame + need[FRAME_W-1:0];
        task_bytes[r.task_id] = saturating_sum(task_bytes[r.task_id], bytes);
        all_bytes = saturating_sum(all_bytes, bytes);
        if (misses_seen != CNT_MAX) misses_seen++;
      end
    end
    o.task_bytes  = task_bytes[r.task_id];
    o.total_bytes = all_bytes;
    o.hit_count   = hits_seen;
    o.miss_count  = misses_seen;
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) mapping_q.insert(mapping_q.size(), predict_translation(req_d));
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (request_q.size() != 0 && idle_on && $urandom_range(0, 3) == 0) begin
          push_gap = $urandom_range(0, 6);
          push <= 1'b0;
        end else if (request_q.size() != 0) begin
          req_d <= request_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (mapping_q.size() == 0) begin
          $error("result item with none expected");
          error_count++;
        end else begin
          e = mapping_q.pop_front();
          check_field("hit", 64'(e.hit), 64'(rsp.hit));
          check_field("out_of_memory", 64'(e.out_of_memory), 64'(rsp.out_of_memory));
          check_field("phys_addr", 64'(e.phys_addr), 64'(rsp.phys_addr));
          check_field("task_bytes", 64'(e.task_bytes), 64'(rsp.task_bytes));
          check_field("total_bytes", 64'(e.total_bytes), 64'(rsp.total_bytes));
          check_field("hit_count", 64'(e.hit_count), 64'(rsp.hit_count));
          check_field("miss_count", 64'(e.miss_count), 64'(rsp.miss_count));
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        pop_gap = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** two_level_page_map_allocator: FAILED **");
      $finish;
    end
  end

  task automatic queue_request(int t, int va, int amt, bit unit);
    req_t r;
    r.task_id         = TASK_W'(t);
    r.virtual_address = VA_W'(va);
    r.size_amount     = AMOUNT_W'(amt);
    r.size_unit       = unit;
    request_q.insert(request_q.size(), r);
  endtask

  task automatic set_frame_limit(logic [FRAME_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    frame_limit = (v > FRAME_LIMIT) ? FRAME_LIMIT : v;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (request_q.size() != 0 || push || mapping_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    req_t                r;
    logic [VA_W-1:0]     va;
    logic [AMOUNT_W-1:0] amt;
    bit                  unit;
    logic [FRAME_W-1:0]  lim;
    foreach (page_map[i]) page_map[i] = '0;
    foreach (task_bytes[i]) task_bytes[i] = '0;
    free_frame  = '0;
    frame_limit = FRAME_LIMIT;
    all_bytes   = '0;
    hits_seen   = '0;
    misses_seen = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(negedge clk_i);
    while (full) @(negedge clk_i);

    // top of the register range is clamped to FRAME_LIMIT as the frame limit
    set_frame_limit('1);
    queue_request(0, 'h000000, 0, 1'b0);
    queue_request(0, 'h0003FF, 7, 1'b0);
    queue_request(3, 'h3FFFFF, 1023, 1'b0);
    queue_request(3, 'h3FFC00, 5, 1'b1);
    queue_request(1, 'h155555, 1023, 1'b1);
    queue_request(2, 'h2AAAAA, 1, 1'b1);
    queue_request(2, 'h2AAC00, 1, 1'b0);
    queue_request(1, 'h155400, 0, 1'b1);
    queue_request(0, 'h000400, 1, 1'b0);
    queue_request(0, 'h3FFC00, 512, 1'b1);
    queue_request(1, 'h000000, 3, 1'b0);
    queue_request(2, 'h000000, 3, 1'b0);
    drain();

    // two frames left: one-over request fails, zero-size maps without moving
    set_frame_limit(free_frame + FRAME_W'(2));
    queue_request(0, 'h100000, 0, 1'b0);
    queue_request(0, 'h100400, 3, 1'b0);
    queue_request(0, 'h100400, 2, 1'b0);
    queue_request(1, 'h100000, 0, 1'b0);
    queue_request(1, 'h100800, 1, 1'b0);
    queue_request(0, 'h1003FF, 9, 1'b1);
    drain();

    // frame pointer now beyond the limit
    set_frame_limit('0);
    queue_request(2, 'h200000, 0, 1'b0);
    queue_request(2, 'h200000, 3, 1'b1);
    queue_request(3, 'h3FFFFF, 0, 1'b0);
    drain();

    set_frame_limit(FRAME_LIMIT + FRAME_W'(1));
    for (int p = 0; p < 6; p++) begin
      case (p)
        0, 5:    lim = FRAME_LIMIT;
        1:       lim = free_frame + FRAME_W'($urandom_range(0, 2000));
        2:       lim = FRAME_W'($urandom);
        3:       lim = '1;
        default: lim = free_frame + FRAME_W'($urandom_range(0, 300));
      endcase
      set_frame_limit(lim);
      idle_on = (p != 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        va = VA_W'($urandom);
        if ($urandom_range(0, 9) < 6) begin
          va[OFFSET_BITS +: INNER_BITS] = INNER_BITS'($urandom_range(0, 7));
          va[OFFSET_BITS + INNER_BITS +: OUTER_BITS] = OUTER_BITS'($urandom_range(0, 3));
        end
        unit = ($urandom_range(0, 9) == 0);
        if (unit)
          amt = ($urandom_range(0, 49) == 0) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 3));
        else
          amt = ($urandom_range(0, 19) == 0) ? '0 : AMOUNT_W'($urandom);
        r.task_id         = TASK_W'($urandom_range(0, TASK_COUNT - 1));
        r.virtual_address = va;
        r.size_amount     = amt;
        r.size_unit       = unit;
        request_q.insert(request_q.size(), r);
      end
      drain();
    end

    if (error_count == 0)
      $display("** two_level_page_map_allocator: PASSED **");
    else
      $display("** two_level_page_map_allocator: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tpma_pkg.sv
rtl/core/tpma_ram.sv
rtl/core/tpma_front.sv
rtl/core/tpma_back.sv
rtl/core/two_level_page_map_allocator.sv
bench/tb_two_level_page_map_allocator.sv
